FILE: hw/rtl/bra_pkg.sv
// ============================================================================
// bra_pkg
// shared types and constants for the beat rate averager: register indexes,
// field widths, divider sizing and the controller/datapath interface structs
// ============================================================================
package bra_pkg;

    localparam int IR_W       = 18;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int RATE_W     = 8;
    localparam int AVG_W      = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 18;
    localparam int PROD_W     = TIME_W + RATE_W;

    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 2;

    // shared serial divider: quotient always fits in a rate
    localparam int DIVIDEND_W = 16;
    localparam int DIVISOR_W  = TIME_W;
    localparam int QUOT_W     = RATE_W;
    localparam int STEP_W     = 3;

    localparam logic [DIVIDEND_W-1:0] RATE_NUM = 16'd60000;

    localparam logic [IR_W-1:0]       IR_THRESHOLD_RST = 18'd50000;
    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = 16'd500;
    localparam logic [RATE_W-1:0]     MIN_RATE_RST     = 8'd40;
    localparam logic [RATE_W-1:0]     MAX_RATE_RST     = 8'd120;

    localparam logic [AVG_W-1:0]      AVG_EMPTY        = 9'h1FF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IR_THRESHOLD = 2'd0,
        REG_MIN_INTERVAL = 2'd1,
        REG_MIN_RATE     = 2'd2,
        REG_MAX_RATE     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic mult;
        logic div_start;
        logic div_sel_mean;
        logic store;
        logic save_mean;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic in_range;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

FILE: hw/rtl/bra_divider.sv
// ============================================================================
// bra_divider
// restoring divider, one quotient bit per cycle, for quotients known to fit
// in QUOT_W bits
// ============================================================================
module bra_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [bra_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [bra_pkg::DIVISOR_W-1:0]    divisor,
    output logic                             done,
    output logic [bra_pkg::QUOT_W-1:0]       quotient
);
    import bra_pkg::*;

    localparam int DV_W = DIVISOR_W + QUOT_W - 1;

    logic [DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [DV_W-1:0]       dv_reg, dv_next;
    logic [QUOT_W-1:0]     q_reg, q_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  ge;

    assign ge = (dv_reg[DV_W-1:DIVIDEND_W] == '0) && (dv_reg[DIVIDEND_W-1:0] <= rem_reg);

    always_comb begin
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            dv_next   = {divisor, {(QUOT_W-1){1'b0}}};
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dv_reg[DIVIDEND_W-1:0];
            end
            q_next   = {q_reg[QUOT_W-2:0], ge};
            dv_next  = dv_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(QUOT_W-1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: hw/rtl/bra_datapath.sv
// ============================================================================
// bra_datapath
// configuration registers, sample capture, beat timing, range products,
// rate ring memory with running sum, shared divider and output register
// ============================================================================
module bra_datapath #(
    parameter int RING_DEPTH = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bra_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bra_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic [bra_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bra_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [bra_pkg::M_TUSER_W-1:0]     m_tuser,
    input  bra_pkg::cmd_t                     cmd,
    output bra_pkg::status_t                  status
);
    import bra_pkg::*;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = RATE_W + CNT_W;

    // configuration
    logic [IR_W-1:0]       ir_thr_reg;
    logic [INTERVAL_W-1:0] min_int_reg;
    logic [RATE_W-1:0]     min_rate_reg;
    logic [RATE_W-1:0]     max_rate_reg;

    // sample and beat state
    logic [IR_W-1:0]       ir_reg;
    logic                  seen_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [TIME_W-1:0]     last_reg;
    logic [TIME_W-1:0]     d_reg;
    logic [TIME_W-1:0]     delta;
    logic [PROD_W-1:0]     prod_lo_reg;
    logic [PROD_W-1:0]     prod_hi_reg;
    logic                  taken_reg;
    logic                  stored_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic [RATE_W-1:0]     mean_reg;

    // ring
    logic [RATE_W-1:0]     ring_mem [RING_DEPTH];
    logic [RATE_W-1:0]     old_reg;
    logic [PTR_W-1:0]      wpos_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  ring_full;

    // divider
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_q;

    // output register
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic [M_TUSER_W-1:0]  out_user_reg;
    logic [AVG_W-1:0]      avg_value;

    assign delta     = time_reg - last_reg;
    assign ring_full = (fill_reg == CNT_W'(RING_DEPTH));
    assign sum_next  = sum_reg + SUM_W'(div_q) - (ring_full ? SUM_W'(old_reg) : '0);
    assign avg_value = (fill_reg == '0) ? AVG_EMPTY : {1'b0, mean_reg};

    assign div_dividend = cmd.div_sel_mean ? DIVIDEND_W'(sum_reg) : RATE_NUM;
    assign div_divisor  = cmd.div_sel_mean ? DIVISOR_W'(fill_reg) : d_reg;

    assign status.hit      = seen_reg && (ir_reg > ir_thr_reg)
                             && (delta >= TIME_W'(min_int_reg));
    assign status.in_range = (prod_lo_reg <= PROD_W'(RATE_NUM))
                             && (prod_hi_reg >= PROD_W'(RATE_NUM));
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || m_tready;

    bra_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ir_thr_reg   <= IR_THRESHOLD_RST;
            min_int_reg  <= MIN_INTERVAL_RST;
            min_rate_reg <= MIN_RATE_RST;
            max_rate_reg <= MAX_RATE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_IR_THRESHOLD: ir_thr_reg   <= cfg_wr_data[IR_W-1:0];
                REG_MIN_INTERVAL: min_int_reg  <= cfg_wr_data[INTERVAL_W-1:0];
                REG_MIN_RATE:     min_rate_reg <= cfg_wr_data[RATE_W-1:0];
                REG_MAX_RATE:     max_rate_reg <= cfg_wr_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg   <= '0;
            taken_reg  <= 1'b0;
            stored_reg <= 1'b0;
            rate_reg   <= '0;
            mean_reg   <= '0;
            wpos_reg   <= '0;
            fill_reg   <= '0;
            sum_reg    <= '0;
        end else begin
            if (cmd.load_in) begin
                taken_reg  <= 1'b0;
                stored_reg <= 1'b0;
                rate_reg   <= '0;
            end
            if (cmd.eval && status.hit) begin
                taken_reg <= 1'b1;
                last_reg  <= time_reg;
            end
            if (cmd.store) begin
                stored_reg <= 1'b1;
                rate_reg   <= div_q;
                sum_reg    <= sum_next;
                wpos_reg   <= (wpos_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wpos_reg + 1'b1;
                if (!ring_full) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.save_mean) begin
                mean_reg <= div_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            ir_reg   <= s_tdata[IR_W-1:0];
            seen_reg <= s_tuser;
            time_reg <= s_tdata[IR_W +: TIME_W];
        end
        if (cmd.eval) begin
            d_reg <= delta;
        end
        if (cmd.mult) begin
            prod_lo_reg <= PROD_W'(min_rate_reg) * PROD_W'(d_reg);
            prod_hi_reg <= PROD_W'(max_rate_reg) * PROD_W'(d_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            ring_mem[wpos_reg] <= div_q;
        end
        old_reg <= ring_mem[wpos_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_data_reg <= {{(M_TDATA_W-AVG_W-RATE_W){1'b0}}, rate_reg, avg_value};
            out_user_reg <= {stored_reg, taken_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(RING_DEPTH))
        else $error("fill count beyond ring depth");

    a_wpos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wpos_reg <= PTR_W'(RING_DEPTH - 1))
        else $error("write position beyond ring");

    a_stored_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && (m_tdata[AVG_W-1:0] != AVG_EMPTY))
        else $error("stored beat without taken beat or with empty average");

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= SUM_W'(fill_reg) * SUM_W'(255))
        else $error("running sum exceeds filled entries");

endmodule

FILE: hw/rtl/bra_ctrl.sv
// ============================================================================
// bra_ctrl
// sequencer for one sample: beat check, range products, rate divide,
// ring update, mean divide and hand-off to the output register
// ============================================================================
module bra_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bra_pkg::status_t    status,
    output bra_pkg::cmd_t       cmd
);
    import bra_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MULT,
        ST_RANGE,
        ST_RATE_GO,
        ST_RATE_WAIT,
        ST_STORE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = status.hit ? ST_MULT : ST_FINISH;
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_RANGE;
            end
            ST_RANGE: begin
                state_next = status.in_range ? ST_RATE_GO : ST_FINISH;
            end
            ST_RATE_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_RATE_WAIT;
            end
            ST_RATE_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = ST_MEAN_GO;
            end
            ST_MEAN_GO: begin
                cmd.div_start    = 1'b1;
                cmd.div_sel_mean = 1'b1;
                state_next       = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                cmd.div_sel_mean = 1'b1;
                cmd.save_mean    = status.div_done;
                if (status.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.out_load = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

FILE: hw/rtl/beat_rate_averager_core.sv
// ============================================================================
// beat_rate_averager_core
// heart-rate moving average over optical samples with external beat flags
//
//   channel   dir  handshake            payload
//   s_        in   s_tvalid/s_tready    tdata: ir_level, time_ms  tuser: beat_seen
//   m_        out  m_tvalid/m_tready    tdata: avg_rate, beat_rate
//                                       tuser: beat_taken, beat_stored
//   cfg_      in   cfg_wr_en            cfg_addr, cfg_wr_data
//
// one request in flight; a sample goes from acceptance back to ready through
// EVAL and FINISH when its beat is not taken, also through MULT and RANGE
// when its rate is out of range, and also through the rate divide, ring store
// and mean divide when it is stored; the stored path makes two passes of the
// shared 8-step serial divider (rate, then mean of the ring)
// reset is synchronous, active low; the ring needs no clearing pass
// a result waits in the output register while the next request is accepted;
// a stalled m_ side only holds the sequencer in its final state
// ============================================================================
module beat_rate_averager_core #(
    parameter int RING_DEPTH = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bra_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bra_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bra_pkg::S_TDATA_W-1:0]     s_tdata,   // ir_level[17:0], time_ms[49:18]
    input  logic                              s_tuser,   // beat_seen
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bra_pkg::M_TDATA_W-1:0]     m_tdata,   // avg_rate[8:0], beat_rate[16:9]
    output logic [bra_pkg::M_TUSER_W-1:0]     m_tuser    // beat_taken[0], beat_stored[1]
);
    import bra_pkg::*;

    cmd_t    cmd;
    status_t status;

    bra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bra_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
